// File: sv/plq_pkg.sv
package plq_pkg;

  // Defaults for the top-level parameters.
  localparam int DEFAULT_DEPTH       = 16;
  localparam int DEFAULT_COORD_WIDTH = 16;

  // Fixed field widths.
  localparam int RADIUS_W = 16;
  localparam int RR_W     = 2 * RADIUS_W;
  localparam int TALLY_W  = 5;

  // Decoded operation, carried from the front end to the back end.
  typedef enum logic [2:0] {
    OP_PUSH,
    OP_POP,
    OP_REMOVE,
    OP_RADIUS,
    OP_SEARCH,
    OP_LENGTH,
    OP_NONE
  } op_t;

  // Fill status of the command queue.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: sv/plq_queue.sv
module plq_queue #(
  parameter int W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [W-1:0]      wdata,
  input  logic              pop,
  output logic [W-1:0]      rdata,
  output plq_pkg::q_stat_t  stat
);
  import plq_pkg::*;

  logic [W-1:0] entry_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   fill_r;
  logic         do_push;
  logic         do_pop;

  // Two-entry FIFO between the front and back ends.
  assign stat.full  = (fill_r == 2'd2);
  assign stat.empty = (fill_r == 2'd0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   fill_r <= fill_r + 2'd1;
        2'b01:   fill_r <= fill_r - 2'd1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

// File: sv/plq_front.sv
module plq_front #(
  parameter int COORD_WIDTH = plq_pkg::DEFAULT_COORD_WIDTH
) (
  input  logic                                     start,
  output logic                                     busy,
  input  logic [2:0]                               in_action,
  input  logic signed [COORD_WIDTH-1:0]            in_point_x,
  input  logic signed [COORD_WIDTH-1:0]            in_point_y,
  input  logic [plq_pkg::RADIUS_W-1:0]             in_radius,
  input  plq_pkg::q_stat_t                         q_stat,
  output logic                                     cmd_push,
  output logic [3+2*COORD_WIDTH+plq_pkg::RR_W-1:0] cmd_word
);
  import plq_pkg::*;

  localparam logic [2:0] ACT_PUSH   = 3'd0;
  localparam logic [2:0] ACT_POP    = 3'd1;
  localparam logic [2:0] ACT_REMOVE = 3'd2;
  localparam logic [2:0] ACT_RADIUS = 3'd3;
  localparam logic [2:0] ACT_SEARCH = 3'd4;
  localparam logic [2:0] ACT_LENGTH = 3'd5;

  op_t             op;
  logic [RR_W-1:0] rr;

  // A beat is taken whenever the queue has room.
  assign busy     = q_stat.full;
  assign cmd_push = start && !q_stat.full;

  // Map the action code onto an operation; unused codes do nothing.
  always_comb begin
    case (in_action)
      ACT_PUSH:   op = OP_PUSH;
      ACT_POP:    op = OP_POP;
      ACT_REMOVE: op = OP_REMOVE;
      ACT_RADIUS: op = OP_RADIUS;
      ACT_SEARCH: op = OP_SEARCH;
      ACT_LENGTH: op = OP_LENGTH;
      default:    op = OP_NONE;
    endcase
  end

  // The squared radius is formed once here so the walk only compares.
  assign rr = RR_W'(in_radius) * RR_W'(in_radius);

  assign cmd_word = {op, in_point_x, in_point_y, rr};

endmodule

// File: sv/plq_back.sv
module plq_back #(
  parameter int DEPTH       = plq_pkg::DEFAULT_DEPTH,
  parameter int COORD_WIDTH = plq_pkg::DEFAULT_COORD_WIDTH
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  plq_pkg::q_stat_t                         q_stat,
  input  logic [3+2*COORD_WIDTH+plq_pkg::RR_W-1:0] cmd_word,
  output logic                                     cmd_pop,
  output logic                                     out_valid,
  output logic [1:0]                               out_status,
  output logic                                     out_found,
  output logic signed [COORD_WIDTH-1:0]            out_hit_x,
  output logic signed [COORD_WIDTH-1:0]            out_hit_y,
  output logic [plq_pkg::TALLY_W-1:0]              out_tally,
  output logic                                     out_last
);
  import plq_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW   = $clog2(DEPTH + 1);
  localparam int SQW  = 2 * CW;
  localparam int CMPW = (SQW + 1 > RR_W) ? SQW + 1 : RR_W;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EMPTY     = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_SHIFT
  } state_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic [CW-1:0]      hx;
    logic [CW-1:0]      hy;
    logic [TALLY_W-1:0] tally;
    logic               last;
  } res_t;

  function automatic res_t mk_res(logic [1:0] status, logic found, logic [CW-1:0] hx,
                                  logic [CW-1:0] hy, logic [NW-1:0] tally, logic last);
    res_t r;
    r.status = status;
    r.found  = found;
    r.hx     = hx;
    r.hy     = hy;
    r.tally  = TALLY_W'(tally);
    r.last   = last;
    return r;
  endfunction

  function automatic logic [CW-1:0] magnitude(logic [CW-1:0] v);
    return v[CW-1] ? (~v + 1'b1) : v;
  endfunction

  // Command fields from the queue head.
  op_t             cmd_op;
  logic [CW-1:0]   cmd_x;
  logic [CW-1:0]   cmd_y;
  logic [RR_W-1:0] cmd_rr;

  assign cmd_op = op_t'(cmd_word[RR_W+SQW +: 3]);
  assign cmd_x  = cmd_word[RR_W+CW +: CW];
  assign cmd_y  = cmd_word[RR_W +: CW];
  assign cmd_rr = cmd_word[RR_W-1:0];

  state_t          state_r;
  logic [NW-1:0]   count_r;
  op_t             op_r;
  logic [CW-1:0]   x_r;
  logic [CW-1:0]   y_r;
  logic [RR_W-1:0] rr_r;

  // Walk pipeline: issue, read data, squares, compare.
  logic            issuing_r;
  logic [AW-1:0]   issue_addr_r;
  logic            s1_v_r;
  logic [AW-1:0]   s1_addr_r;
  logic            s2_v_r;
  logic [AW-1:0]   s2_addr_r;
  logic [CW-1:0]   s2_x_r;
  logic [CW-1:0]   s2_y_r;
  logic [SQW-1:0]  s2_sqx_r;
  logic [SQW-1:0]  s2_sqy_r;
  logic [NW-1:0]   hits_r;
  logic            match_r;
  logic [AW-1:0]   match_addr_r;

  // Compaction after a remove.
  logic            sh_issue_r;
  logic [AW-1:0]   sh_rd_r;
  logic            sh_v_r;
  logic [AW-1:0]   sh_wr_r;

  res_t            out_r;
  logic            out_valid_r;

  // Point memory, front of the list at address count-1.
  logic [SQW-1:0]  mem [DEPTH];
  logic [SQW-1:0]  rd_data_r;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [SQW-1:0]  wr_data;

  logic            list_full;
  logic            list_empty;
  logic [CW-1:0]   s1_x;
  logic [CW-1:0]   s1_y;
  logic [CW-1:0]   mag_x;
  logic [CW-1:0]   mag_y;
  logic [SQW-1:0]  sq_x;
  logic [SQW-1:0]  sq_y;
  logic [CMPW-1:0] dist_sq;
  logic            near;
  logic            same;
  logic            walk_done;

  assign list_full  = (count_r == NW'(DEPTH));
  assign list_empty = (count_r == '0);
  assign cmd_pop    = (state_r == ST_IDLE) && !q_stat.empty;

  // Squares of the point just read.
  assign s1_x  = rd_data_r[SQW-1:CW];
  assign s1_y  = rd_data_r[CW-1:0];
  assign mag_x = magnitude(s1_x);
  assign mag_y = magnitude(s1_y);
  assign sq_x  = mag_x * mag_x;
  assign sq_y  = mag_y * mag_y;

  // Distance test and exact match on the squared stage.
  assign dist_sq   = CMPW'(s2_sqx_r) + CMPW'(s2_sqy_r);
  assign near      = (dist_sq <= CMPW'(rr_r));
  assign same      = (s2_x_r == x_r) && (s2_y_r == y_r);
  assign walk_done = !issuing_r && !s1_v_r && !s2_v_r;

  // Memory port control.
  always_comb begin
    rd_addr = (state_r == ST_SHIFT) ? sh_rd_r : issue_addr_r;
    if (state_r == ST_SHIFT) begin
      wr_en   = sh_v_r;
      wr_addr = sh_wr_r;
      wr_data = rd_data_r;
    end else begin
      wr_en   = cmd_pop && (cmd_op == OP_PUSH) && !list_full;
      wr_addr = AW'(count_r);
      wr_data = {cmd_x, cmd_y};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Sequencer with the registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      issuing_r   <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      sh_issue_r  <= 1'b0;
      sh_v_r      <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      s1_v_r      <= 1'b0;
      sh_v_r      <= 1'b0;

      // Pipeline data moves every cycle.
      s2_v_r    <= s1_v_r;
      s2_addr_r <= s1_addr_r;
      s2_x_r    <= s1_x;
      s2_y_r    <= s1_y;
      s2_sqx_r  <= sq_x;
      s2_sqy_r  <= sq_y;

      case (state_r)
        ST_IDLE: begin
          if (!q_stat.empty) begin
            op_r    <= cmd_op;
            x_r     <= cmd_x;
            y_r     <= cmd_y;
            rr_r    <= cmd_rr;
            hits_r  <= '0;
            match_r <= 1'b0;
            case (cmd_op)
              OP_PUSH: begin
                out_valid_r <= 1'b1;
                if (list_full) begin
                  out_r <= mk_res(STAT_FULL, 1'b0, '0, '0, '0, 1'b1);
                end else begin
                  count_r <= count_r + 1'b1;
                  out_r   <= mk_res(STAT_OK, 1'b0, '0, '0, '0, 1'b1);
                end
              end
              OP_POP: begin
                out_valid_r <= 1'b1;
                if (list_empty) begin
                  out_r <= mk_res(STAT_EMPTY, 1'b0, '0, '0, '0, 1'b1);
                end else begin
                  count_r <= count_r - 1'b1;
                  out_r   <= mk_res(STAT_OK, 1'b0, '0, '0, '0, 1'b1);
                end
              end
              OP_LENGTH: begin
                out_valid_r <= 1'b1;
                out_r       <= mk_res(STAT_OK, 1'b0, '0, '0, count_r, 1'b1);
              end
              OP_REMOVE, OP_SEARCH, OP_RADIUS: begin
                if (list_empty) begin
                  out_valid_r <= 1'b1;
                  if (cmd_op == OP_REMOVE) begin
                    out_r <= mk_res(STAT_NOT_FOUND, 1'b0, '0, '0, '0, 1'b1);
                  end else begin
                    out_r <= mk_res(STAT_OK, 1'b0, '0, '0, '0, 1'b1);
                  end
                end else begin
                  state_r      <= ST_WALK;
                  issuing_r    <= 1'b1;
                  issue_addr_r <= AW'(count_r - 1'b1);
                end
              end
              default: begin
                out_valid_r <= 1'b1;
                out_r       <= mk_res(STAT_OK, 1'b0, '0, '0, '0, 1'b1);
              end
            endcase
          end
        end

        ST_WALK: begin
          // Read addresses run from the front of the list to the back.
          if (issuing_r) begin
            s1_v_r    <= 1'b1;
            s1_addr_r <= issue_addr_r;
            if (issue_addr_r == '0) begin
              issuing_r <= 1'b0;
            end else begin
              issue_addr_r <= issue_addr_r - 1'b1;
            end
          end

          if (s2_v_r) begin
            if (op_r == OP_RADIUS) begin
              if (near) begin
                out_valid_r <= 1'b1;
                out_r       <= mk_res(STAT_OK, 1'b0, s2_x_r, s2_y_r, '0, 1'b0);
                hits_r      <= hits_r + 1'b1;
              end
            end else if (same && !match_r) begin
              match_r      <= 1'b1;
              match_addr_r <= s2_addr_r;
            end
          end

          if (walk_done) begin
            case (op_r)
              OP_RADIUS: begin
                out_valid_r <= 1'b1;
                out_r       <= mk_res(STAT_OK, 1'b0, '0, '0, hits_r, 1'b1);
                state_r     <= ST_IDLE;
              end
              OP_SEARCH: begin
                out_valid_r <= 1'b1;
                out_r       <= mk_res(STAT_OK, match_r, '0, '0, '0, 1'b1);
                state_r     <= ST_IDLE;
              end
              default: begin
                if (!match_r) begin
                  out_valid_r <= 1'b1;
                  out_r       <= mk_res(STAT_NOT_FOUND, 1'b0, '0, '0, '0, 1'b1);
                  state_r     <= ST_IDLE;
                end else if ((NW'(match_addr_r) + 1'b1) == count_r) begin
                  // The match is the front entry: nothing to move.
                  count_r     <= count_r - 1'b1;
                  out_valid_r <= 1'b1;
                  out_r       <= mk_res(STAT_OK, 1'b0, '0, '0, '0, 1'b1);
                  state_r     <= ST_IDLE;
                end else begin
                  state_r    <= ST_SHIFT;
                  sh_issue_r <= 1'b1;
                  sh_rd_r    <= match_addr_r + 1'b1;
                end
              end
            endcase
          end
        end

        ST_SHIFT: begin
          // Each entry above the removed one moves down by one address.
          if (sh_issue_r) begin
            sh_v_r  <= 1'b1;
            sh_wr_r <= sh_rd_r - 1'b1;
            if ((NW'(sh_rd_r) + 1'b1) == count_r) begin
              sh_issue_r <= 1'b0;
            end else begin
              sh_rd_r <= sh_rd_r + 1'b1;
            end
          end else if (sh_v_r) begin
            count_r     <= count_r - 1'b1;
            out_valid_r <= 1'b1;
            out_r       <= mk_res(STAT_OK, 1'b0, '0, '0, '0, 1'b1);
            state_r     <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_r.status;
  assign out_found  = out_r.found;
  assign out_hit_x  = out_r.hx;
  assign out_hit_y  = out_r.hy;
  assign out_tally  = out_r.tally;
  assign out_last   = out_r.last;

endmodule

// File: sv/point_list_with_radius_query.sv
// Ordered list of up to DEPTH signed points, newest first, with push, pop,
// remove, search, length and radius query commands. A command is taken on a
// clock edge where start is high and busy is low; a two-entry command queue
// lets a few commands be posted while earlier ones run. Results appear on the
// out_ ports for exactly one cycle each, marked by out_valid, and cannot be
// held off: the receiver must take every beat as it comes. Push, pop, length
// and unused codes give their result from the register loaded as they leave
// the queue. Search, remove and radius query walk the stored points, one per
// cycle, through a memory with one read and one write port; a remove that
// hits an entry behind the front then moves each entry in front of it down by
// one address to close the gap.
// The last result of every command has out_last set; a radius query first
// gives one beat per point inside the radius, front to back, then a closing
// beat whose out_tally is the number of hits.
module point_list_with_radius_query #(
  parameter int DEPTH       = plq_pkg::DEFAULT_DEPTH,
  parameter int COORD_WIDTH = plq_pkg::DEFAULT_COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    in_action,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic [plq_pkg::RADIUS_W-1:0]  in_radius,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic                          out_found,
  output logic signed [COORD_WIDTH-1:0] out_hit_x,
  output logic signed [COORD_WIDTH-1:0] out_hit_y,
  output logic [plq_pkg::TALLY_W-1:0]   out_tally,
  output logic                          out_last
);
  import plq_pkg::*;

  localparam int QW = 3 + 2 * COORD_WIDTH + RR_W;

  q_stat_t       q_stat;
  logic          cmd_push;
  logic          cmd_pop;
  logic [QW-1:0] cmd_in;
  logic [QW-1:0] cmd_out;

  plq_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .start      (start),
    .busy       (busy),
    .in_action  (in_action),
    .in_point_x (in_point_x),
    .in_point_y (in_point_y),
    .in_radius  (in_radius),
    .q_stat     (q_stat),
    .cmd_push   (cmd_push),
    .cmd_word   (cmd_in)
  );

  plq_queue #(
    .W(QW)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .stat  (q_stat)
  );

  plq_back #(
    .DEPTH       (DEPTH),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .cmd_word   (cmd_out),
    .cmd_pop    (cmd_pop),
    .out_valid  (out_valid),
    .out_status (out_status),
    .out_found  (out_found),
    .out_hit_x  (out_hit_x),
    .out_hit_y  (out_hit_y),
    .out_tally  (out_tally),
    .out_last   (out_last)
  );

endmodule
